// ----- hdl/sorted_array_priority_queue_macros.svh -----
// ----------------------------------------------------------------------------
// Sorted array priority queue - assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SAPQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sapq check failed");

// next-cycle implication
`define SAPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sapq check failed");

`endif

// ----- hdl/sapq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue - package
// Item types, status codes and cell link types.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int unsigned Depth      = 8;
  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CountWidth = $clog2(Depth + 1);

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } sapq_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } sapq_status_e;

  typedef logic signed [ValueWidth-1:0] sapq_value_t;

  typedef struct packed {
    sapq_cmd_e   cmd;
    sapq_value_t value;
  } sapq_req_t;

  typedef struct packed {
    sapq_status_e          status;
    logic [CountWidth-1:0] entry_count;
    sapq_value_t           head_value;
    logic                  head_valid;
  } sapq_rsp_t;

  // broadcast to every cell
  typedef struct packed {
    logic        ins_go;
    logic        del_go;
    sapq_value_t value;
  } sapq_op_t;

  // what a cell shows its neighbors
  typedef struct packed {
    sapq_value_t value;
    logic        valid;
    logic        ins;    // insert point is here or to the left
  } sapq_link_t;

endpackage

// ----- hdl/sapq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue - cell
// Holds one entry; shifts right on insert, left on delete.
// ----------------------------------------------------------------------------
module sapq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sapq_pkg::sapq_op_t   op_i,
  input  sapq_pkg::sapq_link_t left_i,
  input  sapq_pkg::sapq_link_t right_i,
  output sapq_pkg::sapq_link_t link_o,
  output logic                eq_o
);
  import sapq_pkg::*;

  sapq_value_t value_q, value_d;
  logic        valid_q, valid_d;
  logic        gt, ge;

  always_comb begin
    gt = valid_q && (value_q > op_i.value);
    ge = valid_q && (value_q >= op_i.value);
    eq_o = valid_q && (value_q == op_i.value);
    link_o.value = value_q;
    link_o.valid = valid_q;
    link_o.ins   = gt || !valid_q;
  end

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (op_i.ins_go) begin
      if (left_i.ins) begin
        value_d = left_i.value;
        valid_d = left_i.valid;
      end else if (link_o.ins) begin
        value_d = op_i.value;
        valid_d = 1'b1;
      end
    end else if (op_i.del_go && ge) begin
      value_d = right_i.value;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- hdl/sorted_array_priority_queue.sv -----
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; every cell
// compares against the broadcast value and shifts with its neighbor in the same cycle.
// Reset clears the valid bit of every cell, the entry count and the output.
// ----------------------------------------------------------------------------
// Sorted array priority queue - top level
// Ascending list kept in a row of cells, insert and delete by value.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sapq_pkg::sapq_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sapq_pkg::sapq_rsp_t  out_rsp_o
);
  import sapq_pkg::*;

  localparam int unsigned CW = $clog2(Depth + 1);

  sapq_op_t               op;
  sapq_link_t             link   [Depth];
  sapq_link_t             left_l [Depth];
  sapq_link_t             right_l[Depth];
  logic [Depth-1:0]       eq;
  logic                   accept, full, empty, found;
  logic [CW-1:0]          count_q, count_d;
  sapq_status_e           status_q, status_d;
  logic                   out_valid_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign full       = (count_q == CW'(Depth));
  assign empty      = (count_q == '0);
  assign found      = |eq;

  always_comb begin
    op.value  = in_req_i.value;
    op.ins_go = accept && (in_req_i.cmd == CMD_INSERT) && !full;
    op.del_go = accept && (in_req_i.cmd == CMD_DELETE) && found;
  end

  for (genvar k = 0; k < Depth; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_l[k] = '{value: '0, valid: 1'b0, ins: 1'b0};
    end else begin : g_mid
      assign left_l[k] = link[k-1];
    end
    if (k == Depth - 1) begin : g_last
      assign right_l[k] = '{value: '0, valid: 1'b0, ins: 1'b1};
    end else begin : g_rest
      assign right_l[k] = link[k+1];
    end

    sapq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .left_i (left_l[k]),
      .right_i(right_l[k]),
      .link_o (link[k]),
      .eq_o   (eq[k])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    if (in_req_i.cmd == CMD_INSERT) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else if (!found) begin
        status_d = ST_NOTFOUND;
      end else begin
        count_d = count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      status_q    <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        status_q    <= status_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // head is read straight from the first cell; it only moves on accept
  always_comb begin
    out_rsp_o.status      = status_q;
    out_rsp_o.entry_count = CountWidth'(count_q);
    out_rsp_o.head_valid  = link[0].valid;
    out_rsp_o.head_value  = link[0].valid ? link[0].value : '0;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/sapq_checker.sv -----
// ----------------------------------------------------------------------------
// Sorted array priority queue - port checker
// Watches the top level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_macros.svh"

module sapq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sapq_pkg::sapq_rsp_t  out_rsp_o
);
  import sapq_pkg::*;

  logic in_acc;
  logic out_hold;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;

  // every accepted item yields a result in the next cycle
  `SAPQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, in_acc, out_valid_o)

  // a held result does not change
  `SAPQ_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_hold,
                    out_valid_o && $stable(out_rsp_o))

  // empty queue shows a zero head
  `SAPQ_ASSERT_NOW(a_empty_head, clk_i, rst_ni,
                   out_valid_o && !out_rsp_o.head_valid,
                   out_rsp_o.head_value == '0)

  // a refused insert only happens at full capacity
  `SAPQ_ASSERT_NOW(a_full_count, clk_i, rst_ni,
                   out_valid_o && (out_rsp_o.status == ST_FULL),
                   out_rsp_o.entry_count == CountWidth'(Depth) &&
                   out_rsp_o.head_valid)

endmodule

bind sorted_array_priority_queue sapq_checker u_sapq_checker (.*);

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted array priority queue - testbench
// Drives insert and delete requests and keeps its own sorted copy of the
// store to predict status, count and head of every result. Covers empty,
// full, not-found and duplicate cases, then random traffic with gaps and
// back-pressure.
// ----------------------------------------------------------------------------
module tb;

  import sapq_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandItems  = 400;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  sapq_req_t in_req_i    = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  sapq_rsp_t out_rsp_o;

  sorted_array_priority_queue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  // own copy of the store, ascending, oldest first among equals
  sapq_value_t sorted_store[$];
  sapq_rsp_t   predicted_report_q[$];

  int unsigned err_count    = 0;
  int unsigned cycle_count  = 0;
  int unsigned insert_count = 0;
  int unsigned delete_count = 0;
  int unsigned status_seen[4];
  int unsigned burst_left   = 0;
  bit          gaps_enabled = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // apply one request to the store and return the result it should give
  function automatic sapq_rsp_t update_sorted_store(input sapq_req_t req);
    sapq_rsp_t   rsp;
    int unsigned pos;
    bit          hit;
    rsp = '0;
    rsp.status = ST_DONE;
    hit = 1'b0;
    pos = 0;
    if (req.cmd == CMD_INSERT) begin
      if (sorted_store.size() >= Depth) begin
        rsp.status = ST_FULL;
      end else begin
        pos = sorted_store.size();
        for (int k = 0; k < sorted_store.size(); k++) begin
          if (!hit && sorted_store[k] > req.value) begin
            pos = k;
            hit = 1'b1;
          end
        end
        sorted_store.insert(pos, req.value);
      end
    end else begin
      if (sorted_store.size() == 0) begin
        rsp.status = ST_EMPTY;
      end else begin
        for (int k = 0; k < sorted_store.size(); k++) begin
          if (!hit && sorted_store[k] == req.value) begin
            pos = k;
            hit = 1'b1;
          end
        end
        if (hit) sorted_store.delete(pos);
        else rsp.status = ST_NOTFOUND;
      end
    end
    rsp.entry_count = CountWidth'(sorted_store.size());
    rsp.head_valid  = (sorted_store.size() > 0);
    rsp.head_value  = (sorted_store.size() > 0) ? sorted_store[0] : '0;
    return rsp;
  endfunction

  // accepted items feed the prediction, accepted results are checked
  always @(posedge clk_i) begin
    sapq_rsp_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_req_i.cmd == CMD_INSERT) insert_count++;
        else delete_count++;
        predicted_report_q.push_back(update_sorted_store(in_req_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_report_q.size() == 0) begin
          $error("result with no item pending: status %0d count %0d",
                 out_rsp_o.status, out_rsp_o.entry_count);
          err_count++;
        end else begin
          want = predicted_report_q.pop_front();
          status_seen[want.status]++;
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            err_count++;
          end
          if (out_rsp_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d",
                   want.entry_count, out_rsp_o.entry_count);
            err_count++;
          end
          if (out_rsp_o.head_value !== want.head_value) begin
            $error("head_value: expected %0d, got %0d",
                   want.head_value, out_rsp_o.head_value);
            err_count++;
          end
          if (out_rsp_o.head_valid !== want.head_valid) begin
            $error("head_valid: expected %0d, got %0d",
                   want.head_valid, out_rsp_o.head_valid);
            err_count++;
          end
        end
      end
    end
  end

  // receiver back-pressure, switching pattern at random intervals
  always @(posedge clk_i) begin
    stall_mode_e mode;
    int unsigned mode_left;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 1) == 1);
        STALL_HEAVY:    out_stall_i <= ($urandom_range(0, 7) != 0);
        STALL_PERIODIC: out_stall_i <= cycle_count[2];
        default:        out_stall_i <= 1'b0;
      endcase
    end
  end

  // valid stays high between back-to-back items; gaps only at burst ends
  task automatic send_req(input sapq_cmd_e cmd, input sapq_value_t value);
    int unsigned gap;
    sapq_req_t   req;
    req.cmd   = cmd;
    req.value = value;
    if (burst_left == 0) begin
      gap = gaps_enabled ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (predicted_report_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_store();
    send_req(CMD_DELETE, 16'sd0);
    wait_drained();
  endtask

  task automatic test_extremes();
    send_req(CMD_INSERT, 16'sh7fff);
    send_req(CMD_INSERT, sapq_value_t'(16'h8000));
    send_req(CMD_INSERT, 16'sd0);
    send_req(CMD_INSERT, -16'sd1);
    send_req(CMD_INSERT, 16'sd1);
    send_req(CMD_DELETE, 16'sd2);
    send_req(CMD_DELETE, sapq_value_t'(16'h8000));
    send_req(CMD_DELETE, 16'sh7fff);
    wait_drained();
  endtask

  // three entries left from before; fill with duplicates, overflow, pick
  task automatic test_full_and_duplicates();
    send_req(CMD_INSERT, 16'sd5);
    send_req(CMD_INSERT, -16'sd3);
    send_req(CMD_INSERT, 16'sd5);
    send_req(CMD_INSERT, sapq_value_t'(16'h5555));
    send_req(CMD_INSERT, 16'sd5);
    send_req(CMD_INSERT, sapq_value_t'(16'haaaa));
    send_req(CMD_DELETE, 16'sd5);
    send_req(CMD_INSERT, -16'sd100);
    send_req(CMD_INSERT, -16'sd100);
    send_req(CMD_DELETE, 16'sd7);
    send_req(CMD_DELETE, 16'sd5);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned n);
    sapq_value_t pool[6];
    bit          filling;
    sapq_cmd_e   cmd;
    sapq_value_t value;
    filling = 1'b1;
    pool[0] = sapq_value_t'(16'h8000);
    pool[1] = 16'sh7fff;
    for (int k = 2; k < 6; k++) pool[k] = sapq_value_t'($urandom);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) gaps_enabled = ($urandom_range(0, 3) != 0);
      if (i % 100 == 99) wait_drained();
      if (sorted_store.size() >= Depth) filling = 1'b0;
      else if (sorted_store.size() == 0) filling = 1'b1;
      else if ($urandom_range(0, 29) == 0) filling = ~filling;
      if ($urandom_range(0, 99) < 8) begin
        cmd   = sapq_cmd_e'($urandom_range(0, 1));
        value = sapq_value_t'($urandom);
      end else begin
        cmd = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? CMD_INSERT : CMD_DELETE;
        if (cmd == CMD_DELETE && sorted_store.size() != 0 && $urandom_range(0, 99) < 75)
          value = sorted_store[$urandom_range(0, sorted_store.size() - 1)];
        else if ($urandom_range(0, 99) < 60)
          value = pool[$urandom_range(0, 5)];
        else
          value = sapq_value_t'($urandom);
      end
      send_req(cmd, value);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_extremes();
    test_full_and_duplicates();
    test_random_traffic(RandItems);
    repeat (4) @(posedge clk_i);
    $display("Ran %0d inserts and %0d deletes over %0d cycles.",
             insert_count, delete_count, cycle_count);
    $display("Results by status: done %0d, full %0d, empty %0d, not found %0d.",
             status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND]);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
